@@ design/spsl_pkg.sv @@
package spsl_pkg;

  // Spectrum geometry
  localparam int FFT_POINTS = 2048;
  localparam int CNT_W      = 11;
  localparam logic [CNT_W-1:0] HALF_BINS = CNT_W'(FFT_POINTS / 2);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  // Field widths
  localparam int BIN_W   = 10;
  localparam int SAMP_W  = 16;
  localparam int SQ_W    = 31;
  localparam int PWR_W   = 32;
  localparam int SUM_W   = 34;
  localparam int INC_W   = 32;
  localparam int STEP_W  = 16;
  localparam int STAT_W  = 3;
  localparam int CMD_W   = 2;

  localparam logic [INC_W-1:0] RETUNE_STEP = INC_W'(5);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BIN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ABORT = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_RETUNE   = 3'd0;
  localparam logic [STAT_W-1:0] ST_LOCKED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_SWEEPEND = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOMODE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABORTED  = 3'd4;

  // Register map
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_BIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BIN    = 3'd4;

  typedef struct packed {
    logic [INC_W-1:0]  start_phase_inc;
    logic [STEP_W-1:0] step_limit;
    logic [BIN_W-1:0]  low_bin;
    logic [BIN_W-1:0]  center_bin;
    logic [BIN_W-1:0]  high_bin;
  } cfg_t;

  // One beat leaving the power pipeline
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             last;
    logic [PWR_W-1:0] pwr;
  } item_t;

endpackage

@@ design/spsl_cfg.sv @@
module spsl_cfg
  import spsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output cfg_t                 cfg
);

  // Register file; writes to unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_phase_inc <= INC_W'(10325473);
      cfg.step_limit      <= STEP_W'(2000);
      cfg.low_bin         <= BIN_W'(201);
      cfg.center_bin      <= BIN_W'(205);
      cfg.high_bin        <= BIN_W'(209);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_PHASE: cfg.start_phase_inc <= wr_data;
        REG_STEP_LIMIT:  cfg.step_limit      <= wr_data[STEP_W-1:0];
        REG_LOW_BIN:     cfg.low_bin         <= wr_data[BIN_W-1:0];
        REG_CENTER_BIN:  cfg.center_bin      <= wr_data[BIN_W-1:0];
        REG_HIGH_BIN:    cfg.high_bin        <= wr_data[BIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/spsl_power.sv @@
module spsl_power
  import spsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [SAMP_W-1:0] bin_re,
  input  logic signed [SAMP_W-1:0] bin_im,
  input  logic                     last_bin,
  output logic                     item_valid,
  input  logic                     item_ready,
  output item_t                    item
);

  // Stage 1: input register
  logic                     v1;
  logic [CMD_W-1:0]         cmd1;
  logic                     last1;
  logic signed [SAMP_W-1:0] re1, im1;
  // Stage 2: squares
  logic                     v2;
  logic [CMD_W-1:0]         cmd2;
  logic                     last2;
  logic [SQ_W-1:0]          sq_re2, sq_im2;
  // Stage 3: bin power
  logic                     v3;

  logic ld1, ld2, ld3;
  logic signed [2*SAMP_W-1:0] sq_re_full, sq_im_full;

  // Elastic advance: a stage loads when it is empty or its content moves on
  assign ld3      = !v3 || item_ready;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  assign sq_re_full = (2*SAMP_W)'(re1) * (2*SAMP_W)'(re1);
  assign sq_im_full = (2*SAMP_W)'(im1) * (2*SAMP_W)'(im1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (ld1) begin
      cmd1  <= cmd;
      last1 <= last_bin;
      re1   <= bin_re;
      im1   <= bin_im;
    end
    if (ld2) begin
      cmd2   <= cmd1;
      last2  <= last1;
      sq_re2 <= sq_re_full[SQ_W-1:0];
      sq_im2 <= sq_im_full[SQ_W-1:0];
    end
    if (ld3) begin
      item.cmd  <= cmd2;
      item.last <= last2;
      item.pwr  <= PWR_W'({1'b0, sq_re2}) + PWR_W'({1'b0, sq_im2});
    end
  end

  assign item_valid = v3;

endmodule

@@ design/spsl_exec.sv @@
module spsl_exec
  import spsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [INC_W-1:0]  phase_out,
  output logic [SUM_W-1:0]  peak_power,
  output logic [STEP_W-1:0] step_index
);

  // Sweep state
  logic [CNT_W-1:0]  bin_counter, bin_counter_next;
  logic [SUM_W-1:0]  low_sum, low_sum_next;
  logic [SUM_W-1:0]  ctr_sum, ctr_sum_next;
  logic [SUM_W-1:0]  high_sum, high_sum_next;
  logic [SUM_W-1:0]  prev_ctr, prev_ctr_next;
  logic              have_prev, have_prev_next;
  logic [SUM_W-1:0]  best_ctr, best_ctr_next;
  logic [INC_W-1:0]  best_inc, best_inc_next;
  logic              have_dom, have_dom_next;
  logic [INC_W-1:0]  cur_inc, cur_inc_next;
  logic [STEP_W-1:0] steps, steps_next;
  logic              sweeping, sweeping_next;

  logic              emit, fire, rising, lock;
  logic [STAT_W-1:0] st;
  logic [INC_W-1:0]  ph;
  logic [SUM_W-1:0]  pwr, l_new, c_new, h_new;

  // Bin index within centre +/- 1, clipped to the lower half spectrum
  function automatic logic in_band(logic [CNT_W-1:0] idx, logic [BIN_W-1:0] ctr);
    logic [CNT_W-1:0] lo, hi;
    lo = (ctr > BIN_W'(1)) ? CNT_W'(ctr) - CNT_W'(1) : '0;
    hi = CNT_W'(ctr) + CNT_W'(1);
    if (hi >= HALF_BINS) hi = HALF_BINS - CNT_W'(1);
    return (idx < HALF_BINS) && (idx >= lo) && (idx <= hi);
  endfunction

  assign pwr   = SUM_W'(item.pwr);
  assign l_new = in_band(bin_counter, cfg.low_bin)    ? low_sum  + pwr : low_sum;
  assign c_new = in_band(bin_counter, cfg.center_bin) ? ctr_sum  + pwr : ctr_sum;
  assign h_new = in_band(bin_counter, cfg.high_bin)   ? high_sum + pwr : high_sum;

  assign rising = have_prev && (c_new > prev_ctr) && (c_new > l_new) && (c_new > h_new);

  // Next-state and result for the beat at the head
  always_comb begin
    bin_counter_next = bin_counter;
    low_sum_next     = low_sum;
    ctr_sum_next     = ctr_sum;
    high_sum_next    = high_sum;
    prev_ctr_next    = prev_ctr;
    have_prev_next   = have_prev;
    best_ctr_next    = best_ctr;
    best_inc_next    = best_inc;
    have_dom_next    = have_dom;
    cur_inc_next     = cur_inc;
    steps_next       = steps;
    sweeping_next    = sweeping;
    emit             = 1'b0;
    lock             = 1'b0;
    st               = ST_RETUNE;
    ph               = cur_inc;

    unique case (item.cmd)
      CMD_START: begin
        bin_counter_next = '0;
        low_sum_next     = '0;
        ctr_sum_next     = '0;
        high_sum_next    = '0;
        prev_ctr_next    = '0;
        have_prev_next   = 1'b0;
        best_ctr_next    = '0;
        best_inc_next    = '0;
        have_dom_next    = 1'b0;
        cur_inc_next     = cfg.start_phase_inc;
        steps_next       = '0;
        emit             = 1'b1;
        ph               = cfg.start_phase_inc;
        if (cfg.step_limit == '0) begin
          sweeping_next = 1'b0;
          st            = ST_NOMODE;
        end else begin
          sweeping_next = 1'b1;
          st            = ST_RETUNE;
        end
      end
      CMD_ABORT: begin
        if (sweeping) begin
          sweeping_next    = 1'b0;
          bin_counter_next = '0;
          low_sum_next     = '0;
          ctr_sum_next     = '0;
          high_sum_next    = '0;
          emit             = 1'b1;
          st               = ST_ABORTED;
        end
      end
      CMD_BIN: begin
        if (sweeping) begin
          low_sum_next     = l_new;
          ctr_sum_next     = c_new;
          high_sum_next    = h_new;
          bin_counter_next = (bin_counter != CNT_MAX) ? bin_counter + CNT_W'(1)
                                                      : bin_counter;
          // End of frame: hill-climb decision
          if (item.last) begin
            bin_counter_next = '0;
            low_sum_next     = '0;
            ctr_sum_next     = '0;
            high_sum_next    = '0;
            emit             = 1'b1;
            if (rising) begin
              if (!have_dom || c_new >= best_ctr) begin
                have_dom_next = 1'b1;
                best_ctr_next = c_new;
                best_inc_next = cur_inc;
              end else begin
                lock = 1'b1;
              end
            end else if (have_dom) begin
              lock = 1'b1;
            end

            if (lock) begin
              sweeping_next = 1'b0;
              st            = ST_LOCKED;
              ph            = best_inc;
            end else begin
              prev_ctr_next  = c_new;
              have_prev_next = 1'b1;
              cur_inc_next   = cur_inc + RETUNE_STEP;
              steps_next     = steps + STEP_W'(1);
              if (steps_next >= cfg.step_limit) begin
                sweeping_next = 1'b0;
                st            = have_dom_next ? ST_SWEEPEND : ST_NOMODE;
                ph            = have_dom_next ? best_inc_next : cur_inc_next;
              end else begin
                st = ST_RETUNE;
                ph = cur_inc_next;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Beats without a result never wait on the output register
  assign item_ready = !out_valid || out_ready || !emit;
  assign fire       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
      low_sum     <= '0;
      ctr_sum     <= '0;
      high_sum    <= '0;
      prev_ctr    <= '0;
      have_prev   <= 1'b0;
      best_ctr    <= '0;
      best_inc    <= '0;
      have_dom    <= 1'b0;
      cur_inc     <= '0;
      steps       <= '0;
      sweeping    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        bin_counter <= bin_counter_next;
        low_sum     <= low_sum_next;
        ctr_sum     <= ctr_sum_next;
        high_sum    <= high_sum_next;
        prev_ctr    <= prev_ctr_next;
        have_prev   <= have_prev_next;
        best_ctr    <= best_ctr_next;
        best_inc    <= best_inc_next;
        have_dom    <= have_dom_next;
        cur_inc     <= cur_inc_next;
        steps       <= steps_next;
        sweeping    <= sweeping_next;
      end
      if (fire && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      status     <= st;
      phase_out  <= ph;
      peak_power <= best_ctr_next;
      step_index <= steps_next;
    end
  end

endmodule

@@ design/spectral_peak_sweep_lock.sv @@
// Sweep controller that hill-climbs an oscillator onto a spectral mode.
//
// Input channel (in_valid/in_ready): one beat per command. cmd start loads
// start_phase_inc and reports it; cmd bin carries one FFT bin (bin_re,
// bin_im) of the running frame, last_bin marking the frame's final bin;
// cmd abort ends a running sweep. Bins and aborts while idle give nothing.
// Output channel (out_valid/out_ready): at most one result beat per input
// beat: status, phase_out to program, peak_power, step_index.
// Register port (wr_en/wr_index/wr_data): single-cycle writes, idle only.
//
// Pipeline: an accepted input beat passes the input register, square stage,
// power stage and execute stage, whose output register shows the result.
// Throughput: one beat per cycle while no result stalls, set by the execute
// stage, which adds a bin's power into the band sums and decides the frame.
// Reset empties the pipeline, drops out_valid, loads the register defaults
// and leaves the sweep idle. When the receiver stalls, the pending result
// holds in the output register; bins that produce no result keep flowing,
// and in_ready falls once a result-producing beat waits behind it.
module spectral_peak_sweep_lock
  import spsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [SAMP_W-1:0] bin_re,
  input  logic signed [SAMP_W-1:0] bin_im,
  input  logic                     last_bin,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic [INC_W-1:0]         phase_out,
  output logic [SUM_W-1:0]         peak_power,
  output logic [STEP_W-1:0]        step_index,
  input  logic                     wr_en,
  input  logic [CFG_IDX_W-1:0]     wr_index,
  input  logic [CFG_DAT_W-1:0]     wr_data
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid, item_ready;

  spsl_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  spsl_power u_power (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .bin_re     (bin_re),
    .bin_im     (bin_im),
    .last_bin   (last_bin),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  spsl_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .phase_out  (phase_out),
    .peak_power (peak_power),
    .step_index (step_index)
  );

endmodule

@@ design/spsl_checker.sv @@
module spsl_checker
  import spsl_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] status,
  input logic [INC_W-1:0]  phase_out,
  input logic [SUM_W-1:0]  peak_power
);

  // No result survives a reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(phase_out))
    else $error("result beat changed while stalled");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_ABORTED)
    else $error("undefined status code");

  // A lock or a sweep end needs a recorded peak, which is always above zero
  a_lock_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_LOCKED || status == ST_SWEEPEND) |-> peak_power != '0)
    else $error("lock reported without a peak");

endmodule

bind spectral_peak_sweep_lock spsl_checker u_spsl_checker (.*);

@@ dv/spsl_sweep_checker.sv @@
module spsl_sweep_checker
  import spsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [SAMP_W-1:0] bin_re,
  input  logic signed [SAMP_W-1:0] bin_im,
  input  logic                     last_bin,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STAT_W-1:0]        status,
  input  logic [INC_W-1:0]         phase_out,
  input  logic [SUM_W-1:0]         peak_power,
  input  logic [STEP_W-1:0]        step_index,
  input  logic                     wr_en,
  input  logic [CFG_IDX_W-1:0]     wr_index,
  input  logic [CFG_DAT_W-1:0]     wr_data,
  output int                       fail_count,
  output int                       outstanding,
  output logic                     sweep_live,
  output int                       beats_used,
  output int                       results_seen,
  output logic [4:0]               codes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  // Register values after reset
  localparam logic [INC_W-1:0]  DEF_START_PHASE = 32'd10325473;
  localparam logic [STEP_W-1:0] DEF_STEP_LIMIT  = 16'd2000;
  localparam logic [BIN_W-1:0]  DEF_LOW_BIN     = 10'd201;
  localparam logic [BIN_W-1:0]  DEF_CENTER_BIN  = 10'd205;
  localparam logic [BIN_W-1:0]  DEF_HIGH_BIN    = 10'd209;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [INC_W-1:0]  phase;
    logic [SUM_W-1:0]  power;
    logic [STEP_W-1:0] steps;
  } sweep_result_t;

  sweep_result_t pending_results[$];
  sweep_result_t got, want;

  // Predicted sweep state
  cfg_t              regs;
  logic [CNT_W-1:0]  bin_idx;
  logic [SUM_W-1:0]  low_sum, mid_sum, high_sum, prev_mid, best_mid;
  logic              have_prev, have_peak, active;
  logic [INC_W-1:0]  best_inc, cur_inc;
  logic [STEP_W-1:0] step_cnt;

  int                n_fail, n_beats, n_results;
  logic [4:0]        seen;

  function automatic logic band_hit(input logic [CNT_W-1:0] idx,
                                    input logic [BIN_W-1:0] centre);
    logic [CNT_W-1:0] lo, hi;
    lo = (centre > 1) ? CNT_W'(centre) - 1'b1 : '0;
    hi = CNT_W'(centre) + 1'b1;
    if (hi >= HALF_BINS) hi = HALF_BINS - 1'b1;
    return (idx >= lo) && (idx <= hi);
  endfunction

  task automatic clear_frame();
    bin_idx  = '0;
    low_sum  = '0;
    mid_sum  = '0;
    high_sum = '0;
  endtask

  task automatic post_result(input logic [STAT_W-1:0] st, input logic [INC_W-1:0] ph);
    pending_results.push_back({st, ph, best_mid, step_cnt});
  endtask

  // Hill-climb decision at the end of a frame
  task automatic close_frame();
    logic [SUM_W-1:0] c;
    logic rising, lock;
    c = mid_sum;
    rising = have_prev && (c > prev_mid) && (c > low_sum) && (c > high_sum);
    lock = 1'b0;
    clear_frame();
    if (rising) begin
      if (!have_peak || c >= best_mid) begin
        have_peak = 1'b1;
        best_mid  = c;
        best_inc  = cur_inc;
      end else begin
        lock = 1'b1;
      end
    end else if (have_peak) begin
      lock = 1'b1;
    end
    if (lock) begin
      active = 1'b0;
      post_result(ST_LOCKED, best_inc);
    end else begin
      prev_mid  = c;
      have_prev = 1'b1;
      cur_inc   = cur_inc + RETUNE_STEP;
      step_cnt  = step_cnt + 1'b1;
      if (step_cnt >= regs.step_limit) begin
        active = 1'b0;
        if (have_peak) post_result(ST_SWEEPEND, best_inc);
        else post_result(ST_NOMODE, cur_inc);
      end else begin
        post_result(ST_RETUNE, cur_inc);
      end
    end
  endtask

  // Apply one accepted input beat to the predicted state
  task automatic predict_sweep_beat(input logic [CMD_W-1:0] c,
                                    input logic signed [SAMP_W-1:0] re,
                                    input logic signed [SAMP_W-1:0] im,
                                    input logic last);
    longint sr, si;
    logic [PWR_W-1:0] pwr;
    sr = longint'(re);
    si = longint'(im);
    case (c)
      CMD_START: begin
        n_beats++;
        clear_frame();
        prev_mid  = '0;
        have_prev = 1'b0;
        best_mid  = '0;
        best_inc  = '0;
        have_peak = 1'b0;
        cur_inc   = regs.start_phase_inc;
        step_cnt  = '0;
        if (regs.step_limit == '0) begin
          active = 1'b0;
          post_result(ST_NOMODE, cur_inc);
        end else begin
          active = 1'b1;
          post_result(ST_RETUNE, cur_inc);
        end
      end
      CMD_ABORT: begin
        if (active) begin
          n_beats++;
          active = 1'b0;
          clear_frame();
          post_result(ST_ABORTED, cur_inc);
        end
      end
      CMD_BIN: begin
        if (active) begin
          n_beats++;
          pwr = PWR_W'(sr * sr + si * si);
          if (bin_idx < HALF_BINS) begin
            if (band_hit(bin_idx, regs.low_bin))    low_sum  = low_sum + SUM_W'(pwr);
            if (band_hit(bin_idx, regs.center_bin)) mid_sum  = mid_sum + SUM_W'(pwr);
            if (band_hit(bin_idx, regs.high_bin))   high_sum = high_sum + SUM_W'(pwr);
          end
          if (bin_idx != CNT_MAX) bin_idx = bin_idx + 1'b1;
          if (last) close_frame();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.start_phase_inc = DEF_START_PHASE;
      regs.step_limit      = DEF_STEP_LIMIT;
      regs.low_bin         = DEF_LOW_BIN;
      regs.center_bin      = DEF_CENTER_BIN;
      regs.high_bin        = DEF_HIGH_BIN;
      clear_frame();
      prev_mid  = '0;
      best_mid  = '0;
      best_inc  = '0;
      cur_inc   = '0;
      step_cnt  = '0;
      have_prev = 1'b0;
      have_peak = 1'b0;
      active    = 1'b0;
      pending_results.delete();
      n_fail    = 0;
      n_beats   = 0;
      n_results = 0;
      seen      = '0;
    end else begin
      // Result beat against the oldest expectation
      if (out_valid && out_ready) begin
        got = {status, phase_out, peak_power, step_index};
        n_results++;
        if (status <= ST_ABORTED) seen[status] = 1'b1;
        if (pending_results.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("unexpected result beat: status %0d phase %h power %h step %0d",
                     status, phase_out, peak_power, step_index);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display({"result mismatch: status exp %0d got %0d, phase exp %h got %h, ",
                        "power exp %h got %h, step exp %0d got %0d"},
                       want.status, got.status, want.phase, got.phase,
                       want.power, got.power, want.steps, got.steps);
          end
        end
      end

      // Register writes
      if (wr_en) begin
        case (wr_index)
          REG_START_PHASE: regs.start_phase_inc = wr_data;
          REG_STEP_LIMIT:  regs.step_limit      = wr_data[STEP_W-1:0];
          REG_LOW_BIN:     regs.low_bin         = wr_data[BIN_W-1:0];
          REG_CENTER_BIN:  regs.center_bin      = wr_data[BIN_W-1:0];
          REG_HIGH_BIN:    regs.high_bin        = wr_data[BIN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) predict_sweep_beat(cmd, bin_re, bin_im, last_bin);
    end

    fail_count   <= n_fail;
    outstanding  <= pending_results.size();
    sweep_live   <= active;
    beats_used   <= n_beats;
    results_seen <= n_results;
    codes_seen   <= seen;
  end

endmodule

@@ dv/spectral_peak_sweep_lock_tb.sv @@
module spectral_peak_sweep_lock_tb;
  import spsl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_BEATS  = 550;
  localparam int LONG_FRAME    = 1100;
  localparam int MAX_FRAMES    = 24;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 5_000_000;

  // Frame disturbances
  localparam int TWIST_NONE    = 0;
  localparam int TWIST_ABORT   = 1;
  localparam int TWIST_RESTART = 2;
  localparam int TWIST_UNUSED  = 3;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [SAMP_W-1:0] bin_re;
  logic signed [SAMP_W-1:0] bin_im;
  logic                     last_bin;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        status;
  logic [INC_W-1:0]         phase_out;
  logic [SUM_W-1:0]         peak_power;
  logic [STEP_W-1:0]        step_index;
  logic                     wr_en;
  logic [CFG_IDX_W-1:0]     wr_index;
  logic [CFG_DAT_W-1:0]     wr_data;

  int         fail_count;
  int         outstanding;
  logic       sweep_live;
  int         beats_used;
  int         results_seen;
  logic [4:0] codes_seen;

  bit calm;       // no idling on either side while set
  int band_mid;   // centre bin currently programmed
  int setups;

  spectral_peak_sweep_lock u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .bin_re     (bin_re),
    .bin_im     (bin_im),
    .last_bin   (last_bin),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .phase_out  (phase_out),
    .peak_power (peak_power),
    .step_index (step_index),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  spsl_sweep_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .bin_re       (bin_re),
    .bin_im       (bin_im),
    .last_bin     (last_bin),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .phase_out    (phase_out),
    .peak_power   (peak_power),
    .step_index   (step_index),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .sweep_live   (sweep_live),
    .beats_used   (beats_used),
    .results_seen (results_seen),
    .codes_seen   (codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Keep the register value, fill the bits above its width with noise
  function automatic logic [CFG_DAT_W-1:0] with_junk(input logic [CFG_DAT_W-1:0] v,
                                                     input int w);
    logic [CFG_DAT_W-1:0] m;
    m = (w >= CFG_DAT_W) ? '1 : ((32'd1 << w) - 1);
    return ($urandom & ~m) | (v & m);
  endfunction

  // Offer one input beat after an idle gap and hold it until taken
  task automatic send_beat(input int gap, input logic [CMD_W-1:0] c,
                           input logic signed [SAMP_W-1:0] re,
                           input logic signed [SAMP_W-1:0] im, input logic last);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    bin_re   <= re;
    bin_im   <= im;
    last_bin <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_noise(input int gap, input logic [CMD_W-1:0] c);
    send_beat(gap, c, SAMP_W'($urandom), SAMP_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Stop sending, wait for every pending result and let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_bands(input int lo, input int ce, input int hi);
    write_reg(REG_LOW_BIN,    with_junk(lo, BIN_W));
    write_reg(REG_CENTER_BIN, with_junk(ce, BIN_W));
    write_reg(REG_HIGH_BIN,   with_junk(hi, BIN_W));
    band_mid = ce;
  endtask

  // One spectrum frame: a tone of the given amplitude on the centre band over
  // low noise, or full-range noise. cont drops when the sweep is over.
  task automatic send_frame(input int len, input int amp, input bit noisy, input int twist,
                            input int twist_pos, output bit cont);
    int gap;
    logic signed [SAMP_W-1:0] re, im;
    cont = 1'b1;
    for (int i = 0; i < len; i++) begin
      gap = draw_gap();
      if (i == 0 && gap > 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        gap--;
        if (!sweep_live) begin
          cont = 1'b0;
          return;
        end
      end
      if (i == twist_pos && twist != TWIST_NONE) begin
        case (twist)
          TWIST_ABORT: begin
            send_noise(gap, CMD_ABORT);
            cont = 1'b0;
            return;
          end
          TWIST_RESTART: send_noise(gap, CMD_START);
          default:       send_noise(gap, CMD_UNUSED);
        endcase
        gap = draw_gap();
      end
      if (noisy) begin
        re = SAMP_W'($urandom);
        im = SAMP_W'($urandom);
      end else begin
        im = SAMP_W'(int'($urandom_range(0, 127)) - 64);
        if (i >= band_mid - 1 && i <= band_mid + 1) begin
          re = SAMP_W'((amp > 32767) ? 32767 : amp);
          if ($urandom_range(0, 1)) re = -re;
        end else begin
          re = SAMP_W'(int'($urandom_range(0, 127)) - 64);
        end
      end
      send_beat(gap, CMD_BIN, re, im, i == len - 1);
    end
  endtask

  // Receiver: stall a random number of cycles on each offered result
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    int  base, lo, ce, hi, d, widest, peak, len, amp, twist, r;
    bit  cont, noisy;
    logic [INC_W-1:0]  start_val;
    logic [STEP_W-1:0] steps_val;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    cmd      <= CMD_START;
    bin_re   <= '0;
    bin_im   <= '0;
    last_bin <= 1'b0;
    wr_en    <= 1'b0;
    wr_index <= REG_START_PHASE;
    wr_data  <= '0;
    calm     = 1'b0;
    band_mid = 205;
    setups   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: commands while idle are dropped
    send_beat(draw_gap(), CMD_BIN, 16'sh7FFF, 16'sh8000, 1'b1);
    send_noise(draw_gap(), CMD_ABORT);
    send_noise(draw_gap(), CMD_UNUSED);

    // Start with no steps allowed reports no mode at once
    settle();
    write_reg(REG_STEP_LIMIT, with_junk('0, STEP_W));
    send_noise(draw_gap(), CMD_START);

    // Tiny bands at the bottom edge, increment wraps on the first retune
    settle();
    write_reg(REG_START_PHASE, 32'hFFFF_FFFD);
    write_reg(REG_STEP_LIMIT, with_junk(2, STEP_W));
    write_bands(0, 1, 3);
    for (int i = REG_HIGH_BIN + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), $urandom);
    send_noise(draw_gap(), CMD_START);
    send_beat(draw_gap(), CMD_BIN, 16'sh8000, 16'sh8000, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh8000, 16'sh0000, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh0000, 16'sh7FFF, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh0001, 16'shFFFF, 1'b1);
    send_noise(draw_gap(), CMD_UNUSED);
    send_beat(draw_gap(), CMD_BIN, 16'sh7FFF, 16'sh8000, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh0000, 16'sh0000, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh0010, 16'sh0000, 1'b0);
    send_beat(draw_gap(), CMD_BIN, 16'sh0000, 16'sh0020, 1'b1);

    // Restart mid-frame, then abort with a partial frame
    send_noise(draw_gap(), CMD_START);
    send_noise(draw_gap(), CMD_BIN);
    send_noise(draw_gap(), CMD_BIN);
    send_noise(draw_gap(), CMD_START);
    send_noise(draw_gap(), CMD_BIN);
    send_noise(draw_gap(), CMD_ABORT);

    // Long frame: bins past the half spectrum add nothing,
    // bands sit on the clipped top edge and at bin zero
    settle();
    setups++;
    write_reg(REG_START_PHASE, $urandom);
    write_reg(REG_STEP_LIMIT, with_junk(3, STEP_W));
    write_bands(1022, 1023, 0);
    send_noise(draw_gap(), CMD_START);
    send_frame(LONG_FRAME, 0, 1'b1, TWIST_NONE, 0, cont);
    send_noise(draw_gap(), CMD_ABORT);

    // Random sweeps: a tone that climbs over a few steps and then falls away
    settle();
    base = beats_used;
    while (beats_used - base < RANDOM_BEATS) begin
      settle();
      setups++;
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        lo = $urandom_range(0, 15);
        ce = $urandom_range(0, 15);
        hi = $urandom_range(0, 15);
      end else begin
        ce = $urandom_range(2, 14);
        d  = $urandom_range(2, 5);
        lo = (ce > d) ? ce - d : 0;
        hi = ce + $urandom_range(2, 5);
      end
      widest = (lo > hi) ? lo : hi;
      if (ce > widest) widest = ce;
      case ($urandom_range(0, 7))
        0:       start_val = '0;
        1:       start_val = '1;
        default: start_val = $urandom;
      endcase
      r = $urandom_range(0, 19);
      if (r == 0)      steps_val = '0;
      else if (r == 1) steps_val = '1;
      else             steps_val = STEP_W'($urandom_range(1, 12));
      write_reg(REG_START_PHASE, start_val);
      write_reg(REG_STEP_LIMIT, with_junk(CFG_DAT_W'(steps_val), STEP_W));
      write_bands(lo, ce, hi);

      if ($urandom_range(0, 7) == 0) send_noise(draw_gap(), CMD_BIN);
      send_noise(draw_gap(), CMD_START);
      peak = $urandom_range(1, 10);
      for (int k = 1; k <= MAX_FRAMES; k++) begin
        // Shorten the sweep limit with a frame decision still to come
        if ($urandom_range(0, 9) == 0) begin
          settle();
          if (!sweep_live) break;
          write_reg(REG_STEP_LIMIT, with_junk($urandom_range(0, 6), STEP_W));
        end
        r = $urandom_range(0, 15);
        twist = (r < TWIST_UNUSED + 1) ? r : TWIST_NONE;
        len = widest + 2 + $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0) len = $urandom_range(1, 3);
        noisy = ($urandom_range(0, 7) == 0);
        amp = (k <= peak) ? 2000 * k : 2000 * (2 * peak - k);
        if (amp < 0) amp = 0;
        send_frame(len, amp, noisy, twist, $urandom_range(0, len - 1), cont);
        if (!cont) break;
      end
      settle();
      if (sweep_live) send_noise(draw_gap(), CMD_ABORT);
    end

    calm = 1'b0;
    settle();
    $display("Covered %0d effective input beats and %0d checked results over %0d setups",
             beats_used, results_seen, setups);
    $display("Status codes returned (one bit per code, retune at bit 0): %b", codes_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
